// File: hdl/dqks_pkg.sv
package dqks_pkg;

   localparam int DEPTH       = 32;
   localparam int MAX_RESULTS = 32;
   localparam int DATA_W      = 32;
   localparam int MIDX_W      = 5;
   localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int TOT_W       = $clog2(MAX_RESULTS + 1);

   typedef enum logic [1:0] {
      FUNC_PUSH_FRONT = 2'd0,
      FUNC_POP_FRONT  = 2'd1,
      FUNC_POP_BACK   = 2'd2,
      FUNC_SEARCH     = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD     = 2'd0,
      CELL_SHIFT_IN = 2'd1,
      CELL_ROTATE   = 2'd2
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SCAN = 2'd1,
      ST_FIN  = 2'd2
   } state_type;

   typedef logic signed [DATA_W-1:0] word_type;

endpackage

// File: hdl/deque_with_key_search.sv
// Double-ended queue of signed 32-bit words with key search.
// Request channel (req_valid/req_ready, req_func, req_value): push front,
// pop front, pop back or search for a key. Response channel
// (rsp_valid/rsp_ready): one transfer per push or pop, and one per match of
// a search (front-relative index, rsp_last on the final one) or a single
// not-found transfer.
// Entries sit in a row of cells: a push shifts the row toward the back, a
// pop front rotates it toward the front, a pop back only drops the count.
// Push and pop answer in the cycle after the request transfer and a new
// request is taken every cycle the response register is free and no search runs.
// A search rotates the whole row once past the compare at the front cell,
// one cell a cycle while no new match waits on a stalled receiver, then
// sends the held last match, or a not-found response if nothing matched.
// Reset empties the queue (cell contents are not cleared) and drops any
// pending response. A stalled receiver holds the response register; a
// request waits in the idle state and a search holds its rotation.
module deque_with_key_search (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_func,
   input  logic signed [31:0]               req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [31:0]               rsp_popped_value,
   output logic [4:0]                       rsp_match_index,
   output logic [1:0]                       rsp_status,
   output logic                             rsp_last
);

   logic [dqks_pkg::DEPTH-1:0][dqks_pkg::DATA_W-1:0] cell_data;
   dqks_pkg::word_type                              cell_q [dqks_pkg::DEPTH];
   dqks_pkg::cell_op_type                           cell_op;

   genvar k;
   generate
      for (k = 0; k < dqks_pkg::DEPTH; k++) begin : g_cell
         dqks_pkg::word_type prev_data;
         dqks_pkg::word_type next_data;
         if (k == 0) begin : g_first
            assign prev_data = req_value;
         end else begin : g_inner
            assign prev_data = cell_q[k-1];
         end
         assign next_data = cell_q[(k + 1) % dqks_pkg::DEPTH];
         dqks_cell u_cell (
            .clock     (clock),
            .cell_op   (cell_op),
            .from_prev (prev_data),
            .from_next (next_data),
            .data      (cell_q[k])
         );
         assign cell_data[k] = cell_q[k];
      end
   endgenerate

   dqks_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_popped_value (rsp_popped_value),
      .rsp_match_index  (rsp_match_index),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .cell_data        (cell_data),
      .cell_op          (cell_op)
   );

endmodule

// File: hdl/dqks_cell.sv
module dqks_cell (
   input  logic                  clock,
   input  dqks_pkg::cell_op_type cell_op,
   input  dqks_pkg::word_type    from_prev,
   input  dqks_pkg::word_type    from_next,
   output dqks_pkg::word_type    data
);

   dqks_pkg::word_type data_ff;
   dqks_pkg::word_type data_in;

   always_comb begin
      case (cell_op)
         dqks_pkg::CELL_SHIFT_IN: data_in = from_prev;
         dqks_pkg::CELL_ROTATE:   data_in = from_next;
         default:                 data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// File: hdl/dqks_ctrl.sv
module dqks_ctrl (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic [1:0]                                req_func,
   input  dqks_pkg::word_type                        req_value,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output dqks_pkg::word_type                        rsp_popped_value,
   output logic [dqks_pkg::MIDX_W-1:0]               rsp_match_index,
   output logic [1:0]                                rsp_status,
   output logic                                      rsp_last,
   input  logic [dqks_pkg::DEPTH-1:0][dqks_pkg::DATA_W-1:0] cell_data,
   output dqks_pkg::cell_op_type                     cell_op
);

   dqks_pkg::state_type               state_ff, state_in;
   logic [dqks_pkg::CNT_W-1:0]        count_ff, count_in;
   dqks_pkg::word_type                key_ff, key_in;
   logic [dqks_pkg::IDX_W-1:0]        idx_ff, idx_in;
   logic                              pend_valid_ff, pend_valid_in;
   logic [dqks_pkg::MIDX_W-1:0]       pend_idx_ff, pend_idx_in;
   logic [dqks_pkg::TOT_W-1:0]        tot_ff, tot_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   dqks_pkg::word_type                rsp_popped_ff, rsp_popped_in;
   logic [dqks_pkg::MIDX_W-1:0]       rsp_index_ff, rsp_index_in;
   dqks_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic                              rsp_last_ff, rsp_last_in;

   dqks_pkg::word_type                front;
   dqks_pkg::word_type                back;
   logic                              out_free;
   logic                              hit;
   logic                              stall;

   assign front    = dqks_pkg::word_type'(cell_data[0]);
   assign back     = dqks_pkg::word_type'(
                        cell_data[dqks_pkg::IDX_W'(count_ff - dqks_pkg::CNT_W'(1))]);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign hit      = (dqks_pkg::CNT_W'(idx_ff) < count_ff) && (front == key_ff) &&
                     (tot_ff < dqks_pkg::TOT_W'(dqks_pkg::MAX_RESULTS));
   assign stall    = hit && pend_valid_ff && !out_free;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      tot_in        = tot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_popped_in = rsp_popped_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      cell_op       = dqks_pkg::CELL_HOLD;
      req_ready     = 1'b0;
      case (state_ff)
         dqks_pkg::ST_IDLE: begin
            req_ready = out_free;
            if (req_valid && out_free) begin
               rsp_popped_in = '0;
               rsp_index_in  = '0;
               rsp_status_in = dqks_pkg::STATUS_OK;
               rsp_last_in   = 1'b1;
               case (dqks_pkg::func_type'(req_func))
                  dqks_pkg::FUNC_PUSH_FRONT: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == dqks_pkg::CNT_W'(dqks_pkg::DEPTH)) begin
                        rsp_status_in = dqks_pkg::STATUS_FULL;
                     end else begin
                        cell_op  = dqks_pkg::CELL_SHIFT_IN;
                        count_in = count_ff + dqks_pkg::CNT_W'(1);
                     end
                  end
                  dqks_pkg::FUNC_POP_FRONT: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == '0) begin
                        rsp_status_in = dqks_pkg::STATUS_EMPTY;
                     end else begin
                        cell_op       = dqks_pkg::CELL_ROTATE;
                        count_in      = count_ff - dqks_pkg::CNT_W'(1);
                        rsp_popped_in = front;
                     end
                  end
                  dqks_pkg::FUNC_POP_BACK: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == '0) begin
                        rsp_status_in = dqks_pkg::STATUS_EMPTY;
                     end else begin
                        count_in      = count_ff - dqks_pkg::CNT_W'(1);
                        rsp_popped_in = back;
                     end
                  end
                  default: begin
                     key_in        = req_value;
                     idx_in        = '0;
                     pend_valid_in = 1'b0;
                     tot_in        = '0;
                     state_in      = dqks_pkg::ST_SCAN;
                  end
               endcase
            end
         end
         dqks_pkg::ST_SCAN: begin
            if (!stall) begin
               cell_op = dqks_pkg::CELL_ROTATE;
               idx_in  = idx_ff + dqks_pkg::IDX_W'(1);
               if (hit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_popped_in = '0;
                     rsp_index_in  = pend_idx_ff;
                     rsp_status_in = dqks_pkg::STATUS_OK;
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_idx_in   = dqks_pkg::MIDX_W'(idx_ff);
                  tot_in        = tot_ff + dqks_pkg::TOT_W'(1);
               end
               if (idx_ff == dqks_pkg::IDX_W'(dqks_pkg::DEPTH - 1)) begin
                  state_in = dqks_pkg::ST_FIN;
               end
            end
         end
         dqks_pkg::ST_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_popped_in = '0;
               rsp_last_in   = 1'b1;
               if (pend_valid_ff) begin
                  rsp_index_in  = pend_idx_ff;
                  rsp_status_in = dqks_pkg::STATUS_OK;
               end else begin
                  rsp_index_in  = '0;
                  rsp_status_in = dqks_pkg::STATUS_NOT_FOUND;
               end
               state_in = dqks_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dqks_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dqks_pkg::ST_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      pend_idx_ff   <= pend_idx_in;
      tot_ff        <= tot_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_match_index  = rsp_index_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// File: bench/tb_deque_with_key_search.sv
module tb_deque_with_key_search;

   localparam int ITEM_TARGET = 210;
   localparam int LONG_HOLD   = 200;
   localparam int CYCLE_LIMIT = 500000;
   localparam int MAX_PRINTS  = 30;

   typedef struct packed {
      dqks_pkg::word_type              popped;
      logic [dqks_pkg::MIDX_W-1:0]     index;
      dqks_pkg::status_type            status;
      logic                            last;
   } reply_type;

   typedef struct packed {
      dqks_pkg::func_type              op;
      dqks_pkg::word_type              val;
      logic                            typed;
      dqks_pkg::word_type              popped;
      dqks_pkg::status_type            status;
   } probe_type;

   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } mix_type;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_func  = 2'b00;
   dqks_pkg::word_type   req_value = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   dqks_pkg::word_type   rsp_popped_value;
   logic [4:0]           rsp_match_index;
   logic [1:0]           rsp_status;
   logic                 rsp_last;

   dqks_pkg::word_type           stored_words [dqks_pkg::DEPTH];
   logic [dqks_pkg::IDX_W-1:0]   front_ptr;
   logic [dqks_pkg::CNT_W-1:0]   fill_count;
   reply_type                    step_replies[$];
   reply_type                    awaited_replies[$];

   int                   mismatch_count = 0;
   int                   items_sent     = 0;
   int                   replies_seen   = 0;
   int                   cycle_count    = 0;
   int                   widest_search  = 0;
   int                   ops_sent [4]   = '{0, 0, 0, 0};
   int                   status_seen [4] = '{0, 0, 0, 0};
   int                   burst_left     = 0;
   bit                   hold_off_req   = 1'b0;
   dqks_pkg::word_type   key_pool [4];

   probe_type dir_rows [14] = '{
      '{dqks_pkg::FUNC_POP_FRONT,  '0, 1'b1, '0, dqks_pkg::STATUS_EMPTY},
      '{dqks_pkg::FUNC_POP_BACK,   '0, 1'b1, '0, dqks_pkg::STATUS_EMPTY},
      '{dqks_pkg::FUNC_SEARCH,     '0, 1'b1, '0, dqks_pkg::STATUS_NOT_FOUND},
      '{dqks_pkg::FUNC_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1, '0, dqks_pkg::STATUS_OK},
      '{dqks_pkg::FUNC_PUSH_FRONT, 32'h8000_0000, 1'b1, '0, dqks_pkg::STATUS_OK},
      '{dqks_pkg::FUNC_PUSH_FRONT, '0, 1'b1, '0, dqks_pkg::STATUS_OK},
      '{dqks_pkg::FUNC_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, '0, dqks_pkg::STATUS_OK},
      '{dqks_pkg::FUNC_SEARCH,     32'hFFFF_FFFF, 1'b0, '0, dqks_pkg::STATUS_OK},
      '{dqks_pkg::FUNC_SEARCH,     32'h8000_0000, 1'b0, '0, dqks_pkg::STATUS_OK},
      '{dqks_pkg::FUNC_SEARCH,     32'h1234_5678, 1'b1, '0, dqks_pkg::STATUS_NOT_FOUND},
      '{dqks_pkg::FUNC_POP_BACK,   '0, 1'b1, 32'h7FFF_FFFF, dqks_pkg::STATUS_OK},
      '{dqks_pkg::FUNC_POP_FRONT,  '0, 1'b1, 32'hFFFF_FFFF, dqks_pkg::STATUS_OK},
      '{dqks_pkg::FUNC_PUSH_FRONT, '0, 1'b0, '0, dqks_pkg::STATUS_OK},
      '{dqks_pkg::FUNC_SEARCH,     '0, 1'b0, '0, dqks_pkg::STATUS_OK}
   };

   deque_with_key_search u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_popped_value (rsp_popped_value),
      .rsp_match_index  (rsp_match_index),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic reply_type make_reply(input dqks_pkg::word_type popped,
                                            input logic [dqks_pkg::MIDX_W-1:0] index,
                                            input dqks_pkg::status_type status,
                                            input logic last);
      reply_type r;
      r.popped = popped;
      r.index  = index;
      r.status = status;
      r.last   = last;
      return r;
   endfunction

   function automatic void deque_apply(input dqks_pkg::func_type op,
                                       input dqks_pkg::word_type val);
      int slot;
      int hits;
      step_replies.delete();
      hits = 0;
      case (op)
         dqks_pkg::FUNC_PUSH_FRONT: begin
            if (int'(fill_count) >= dqks_pkg::DEPTH) begin
               step_replies.push_back(make_reply('0, '0, dqks_pkg::STATUS_FULL, 1'b1));
            end else begin
               front_ptr = dqks_pkg::IDX_W'((int'(front_ptr) + dqks_pkg::DEPTH - 1)
                                            % dqks_pkg::DEPTH);
               stored_words[front_ptr] = val;
               fill_count = fill_count + dqks_pkg::CNT_W'(1);
               step_replies.push_back(make_reply('0, '0, dqks_pkg::STATUS_OK, 1'b1));
            end
         end
         dqks_pkg::FUNC_POP_FRONT, dqks_pkg::FUNC_POP_BACK: begin
            if (fill_count == '0) begin
               step_replies.push_back(make_reply('0, '0, dqks_pkg::STATUS_EMPTY, 1'b1));
            end else begin
               if (op == dqks_pkg::FUNC_POP_FRONT) begin
                  slot = int'(front_ptr);
                  front_ptr = dqks_pkg::IDX_W'((int'(front_ptr) + 1) % dqks_pkg::DEPTH);
               end else begin
                  slot = (int'(front_ptr) + int'(fill_count) - 1) % dqks_pkg::DEPTH;
               end
               fill_count = fill_count - dqks_pkg::CNT_W'(1);
               step_replies.push_back(make_reply(stored_words[dqks_pkg::IDX_W'(slot)], '0,
                                                 dqks_pkg::STATUS_OK, 1'b1));
            end
         end
         default: begin
            for (int i = 0; i < int'(fill_count); i++) begin
               slot = (int'(front_ptr) + i) % dqks_pkg::DEPTH;
               if (stored_words[dqks_pkg::IDX_W'(slot)] == val &&
                   hits < dqks_pkg::MAX_RESULTS) begin
                  step_replies.push_back(make_reply('0, dqks_pkg::MIDX_W'(i),
                                                    dqks_pkg::STATUS_OK, 1'b0));
                  hits++;
               end
            end
            if (hits == 0) begin
               step_replies.push_back(make_reply('0, '0, dqks_pkg::STATUS_NOT_FOUND, 1'b1));
            end else begin
               step_replies[hits-1].last = 1'b1;
            end
            if (hits > widest_search) widest_search = hits;
         end
      endcase
   endfunction

   function automatic dqks_pkg::word_type pick_word();
      if ($urandom_range(0, 9) < 6) return key_pool[2'($urandom_range(0, 3))];
      return dqks_pkg::word_type'($urandom);
   endfunction

   function automatic dqks_pkg::word_type pick_key();
      int pos;
      if (fill_count != '0 && $urandom_range(0, 9) < 3) begin
         pos = int'($urandom_range(0, int'(fill_count) - 1));
         return stored_words[dqks_pkg::IDX_W'((int'(front_ptr) + pos) % dqks_pkg::DEPTH)];
      end
      return pick_word();
   endfunction

   function automatic dqks_pkg::func_type pick_op(input mix_type mix);
      int r;
      r = int'($urandom_range(0, 99));
      case (mix)
         MIX_FILL: begin
            if (r < 65) return dqks_pkg::FUNC_PUSH_FRONT;
            if (r < 75) return dqks_pkg::FUNC_POP_FRONT;
            if (r < 85) return dqks_pkg::FUNC_POP_BACK;
            return dqks_pkg::FUNC_SEARCH;
         end
         MIX_DRAIN: begin
            if (r < 15) return dqks_pkg::FUNC_PUSH_FRONT;
            if (r < 50) return dqks_pkg::FUNC_POP_FRONT;
            if (r < 85) return dqks_pkg::FUNC_POP_BACK;
            return dqks_pkg::FUNC_SEARCH;
         end
         default: begin
            return dqks_pkg::func_type'(r % 4);
         end
      endcase
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] wanted);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS)
         $display("mismatch %0d at response %0d, cycle %0d: %s got %0h, wanted %0h",
                  mismatch_count, replies_seen, cycle_count, field, got, wanted);
   endtask

   task automatic send_item(input dqks_pkg::func_type op, input dqks_pkg::word_type val,
                            input logic typed, input reply_type typed_reply);
      req_valid <= 1'b1;
      req_func  <= op;
      req_value <= val;
      do @(posedge clock); while (!req_ready);
      deque_apply(op, val);
      if (typed) begin
         awaited_replies.push_back(typed_reply);
      end else begin
         foreach (step_replies[k]) awaited_replies.push_back(step_replies[k]);
      end
      items_sent++;
      ops_sent[op]++;
   endtask

   task automatic sender_pace();
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(1, 10));
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = int'($urandom_range(1, 16));
      end
      burst_left--;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_replies.size() != 0);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("run timed out at cycle %0d with %0d responses outstanding",
                  cycle_count, awaited_replies.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin : rsp_check
      reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_replies.size() == 0) begin
            report_mismatch("unexpected transfer, status", 32'(rsp_status), 32'(0));
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_popped_value !== want.popped)
               report_mismatch("popped_value", rsp_popped_value, want.popped);
            if (rsp_match_index !== want.index)
               report_mismatch("match_index", 32'(rsp_match_index), 32'(want.index));
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_last !== want.last)
               report_mismatch("last", 32'(rsp_last), 32'(want.last));
         end
         status_seen[rsp_status]++;
         replies_seen++;
      end
   end

   initial begin : rsp_side
      int hold_left;
      int span_left;
      int ready_pct;
      hold_left = 0;
      span_left = 0;
      ready_pct = 100;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (span_left == 0) begin
               span_left = int'($urandom_range(4, 48));
               case ($urandom_range(0, 3))
                  0: ready_pct = 100;
                  1: ready_pct = 75;
                  2: ready_pct = 40;
                  default: ready_pct = 15;
               endcase
            end
            span_left--;
            rsp_ready <= ($urandom_range(0, 99) < ready_pct);
         end
      end
   end

   initial begin : req_side
      reply_type          no_reply;
      dqks_pkg::word_type flood_key;
      dqks_pkg::func_type op;
      mix_type            mix;
      int                 phase_len;
      no_reply   = '0;
      front_ptr  = '0;
      fill_count = '0;
      key_pool[0] = dqks_pkg::word_type'($urandom);
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h8000_0000;
      key_pool[3] = 32'h0000_0000;
      flood_key   = dqks_pkg::word_type'($urandom);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) begin
         send_item(dir_rows[r].op, dir_rows[r].val, dir_rows[r].typed,
                   make_reply(dir_rows[r].popped, '0, dir_rows[r].status, 1'b1));
         sender_pace();
      end

      // empty the queue, then flood it past full while the receiver holds off
      while (fill_count != '0) begin
         send_item(dqks_pkg::FUNC_POP_BACK, dqks_pkg::word_type'($urandom), 1'b0, no_reply);
         sender_pace();
      end
      wait_drained();
      hold_off_req = 1'b1;
      repeat (dqks_pkg::DEPTH + 4)
         send_item(dqks_pkg::FUNC_PUSH_FRONT, flood_key, 1'b0, no_reply);
      send_item(dqks_pkg::FUNC_SEARCH, flood_key, 1'b0, no_reply);
      wait_drained();

      while (items_sent < ITEM_TARGET) begin
         mix = mix_type'($urandom_range(0, 2));
         phase_len = int'($urandom_range(10, 40));
         for (int n = 0; n < phase_len && items_sent < ITEM_TARGET; n++) begin
            op = pick_op(mix);
            send_item(op, (op == dqks_pkg::FUNC_SEARCH) ? pick_key() : pick_word(),
                      1'b0, no_reply);
            sender_pace();
         end
         if ($urandom_range(0, 2) == 0) wait_drained();
      end

      wait_drained();
      repeat (dqks_pkg::DEPTH + 8) @(posedge clock);

      $display("covered %0d requests: %0d push front, %0d pop front, %0d pop back, %0d search",
               items_sent, ops_sent[dqks_pkg::FUNC_PUSH_FRONT],
               ops_sent[dqks_pkg::FUNC_POP_FRONT], ops_sent[dqks_pkg::FUNC_POP_BACK],
               ops_sent[dqks_pkg::FUNC_SEARCH]);
      $display("%0d responses: %0d full, %0d empty, %0d not found, widest search %0d matches",
               replies_seen, status_seen[dqks_pkg::STATUS_FULL],
               status_seen[dqks_pkg::STATUS_EMPTY], status_seen[dqks_pkg::STATUS_NOT_FOUND],
               widest_search);
      if (mismatch_count == 0 && awaited_replies.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
